// ===== design/tunb_pkg.sv =====
package tunb_pkg;

   // Magnitudes are scaled so the largest one lies in [2^30, 2^31).
   localparam int TARGET_BITS = 31;
   localparam int SQ_W        = 2 * TARGET_BITS;

   // Square root of a 64-bit sum of squares, one result bit per stage.
   localparam int RAD_W       = 64;
   localparam int ROOT_W      = RAD_W / 2;
   localparam int ROOT_STEPS  = ROOT_W;
   localparam int ROOT_REM_W  = ROOT_W + 2;

   // Rounded quotient m * 2^14 / L, one quotient bit per stage.
   localparam int QUOT_BITS   = 15;
   localparam int NUM_W       = TARGET_BITS + QUOT_BITS + 1;
   localparam int DEN_W       = ROOT_W + 1;

   // Q1.14 output.
   localparam int NORM_W      = 16;
   localparam int NORM_ONE    = 16384;

   typedef logic signed [NORM_W-1:0] norm_type;

endpackage

// ===== design/triangle_unit_normal_and_box.sv =====
// Triangle unit normal and bounding box.
//
// Input channel: drive the nine vertex coordinates (signed, COORD_BITS wide,
// Q12.12 at the default width) on the req_ ports and raise start. A beat is
// taken at every rising edge where start is high and busy is low. busy is
// high only during reset and the cycle after it, so a new triangle may enter
// on every cycle.
// Result channel: rsp_valid is high for exactly one cycle per triangle, with
// the Q1.14 unit normal, the per-axis box and the degenerate flag on the
// rsp_ ports. The receiver has no way to hold a result off; each one must be
// taken in that cycle.
// Throughput is one triangle per cycle. The depth is set by the 32-stage
// square root (one root bit per stage) and the 15-stage rounding divide
// (one quotient bit per stage), plus eight stages of edge, product, cross,
// magnitude, length, scaling, square and sum, one divide setup stage and
// the output register.
// Reset clears every stage valid bit, so results in flight are dropped and
// no strobe appears until new beats are taken.
module triangle_unit_normal_and_box import tunb_pkg::*; #(
   parameter int COORD_BITS = 24
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic signed [COORD_BITS-1:0] req_vertex_a_x,
   input  logic signed [COORD_BITS-1:0] req_vertex_a_y,
   input  logic signed [COORD_BITS-1:0] req_vertex_a_z,
   input  logic signed [COORD_BITS-1:0] req_vertex_b_x,
   input  logic signed [COORD_BITS-1:0] req_vertex_b_y,
   input  logic signed [COORD_BITS-1:0] req_vertex_b_z,
   input  logic signed [COORD_BITS-1:0] req_vertex_c_x,
   input  logic signed [COORD_BITS-1:0] req_vertex_c_y,
   input  logic signed [COORD_BITS-1:0] req_vertex_c_z,
   output logic                         rsp_valid,
   output logic signed [NORM_W-1:0]     rsp_normal_x,
   output logic signed [NORM_W-1:0]     rsp_normal_y,
   output logic signed [NORM_W-1:0]     rsp_normal_z,
   output logic signed [COORD_BITS-1:0] rsp_box_low_x,
   output logic signed [COORD_BITS-1:0] rsp_box_low_y,
   output logic signed [COORD_BITS-1:0] rsp_box_low_z,
   output logic signed [COORD_BITS-1:0] rsp_box_high_x,
   output logic signed [COORD_BITS-1:0] rsp_box_high_y,
   output logic signed [COORD_BITS-1:0] rsp_box_high_z,
   output logic                         rsp_degenerate
);

   localparam int CB    = COORD_BITS;
   localparam int EW    = CB + 1;           // edge width
   localparam int PW    = 2 * EW;           // product width
   localparam int XW    = PW + 1;           // cross component width
   localparam int MLW   = $clog2(XW + 1);   // bit length of a cross magnitude
   localparam int SH_W  = XW + TARGET_BITS;

   // Stage numbering: register k of the pipe holds stage k.
   localparam int ST_EDGE  = 0;
   localparam int ST_MUL   = 1;
   localparam int ST_CROSS = 2;
   localparam int ST_MAG   = 3;
   localparam int ST_LEN   = 4;
   localparam int ST_NORM  = 5;
   localparam int ST_SQ    = 6;
   localparam int ST_SUM   = 7;
   localparam int ST_ROOT  = 8;
   localparam int ST_PREP  = ST_ROOT + ROOT_STEPS;
   localparam int ST_DIV   = ST_PREP + 1;
   localparam int ST_OUT   = ST_DIV + QUOT_BITS;
   localparam int NUM_ST   = ST_OUT + 1;

   // Data that rides alongside the arithmetic: box, signs, flag, scaled magnitudes.
   typedef struct packed {
      logic [2:0][CB-1:0]          lo;
      logic [2:0][CB-1:0]          hi;
      logic [2:0]                  neg;
      logic                        deg;
      logic [2:0][TARGET_BITS-1:0] m;
   } side_type;

   logic                         accept;
   logic                         busy_ff;
   logic [NUM_ST-1:0]            vld_ff, vld_in;
   side_type                     side_ff [ST_OUT];
   side_type                     side_in [ST_OUT];

   logic signed [CB-1:0]         va [3];
   logic signed [CB-1:0]         vb [3];
   logic signed [CB-1:0]         vc [3];
   logic signed [CB-1:0]         box_lo [3];
   logic signed [CB-1:0]         box_hi [3];

   logic signed [EW-1:0]         e1_ff [3], e1_in [3];
   logic signed [EW-1:0]         e2_ff [3], e2_in [3];
   logic signed [PW-1:0]         prod_ff [6], prod_in [6];
   logic signed [XW-1:0]         cross_ff [3], cross_in [3];
   logic [XW-1:0]                mag_ff [3], mag_in [3];
   logic [2:0]                   neg_c;
   logic                         deg_c;
   logic [XW-1:0]                mag2_ff [3];
   logic [MLW-1:0]               len_ff, len_in;
   logic [TARGET_BITS-1:0]       m_c [3];
   logic [SQ_W-1:0]              sq_ff [3], sq_in [3];
   logic [RAD_W-1:0]             s_ff, s_in;

   logic [RAD_W-1:0]             rt_rad_ff [ROOT_STEPS], rt_rad_in [ROOT_STEPS];
   logic [ROOT_REM_W-1:0]        rt_rem_ff [ROOT_STEPS], rt_rem_in [ROOT_STEPS];
   logic [ROOT_W-1:0]            rt_root_ff [ROOT_STEPS], rt_root_in [ROOT_STEPS];

   logic [NUM_W-1:0]             num_ff [3], num_in [3];
   logic [DEN_W-1:0]             den_ff, den_in;

   logic [DEN_W-1:0]             dv_rem_ff [QUOT_BITS][3], dv_rem_in [QUOT_BITS][3];
   logic [QUOT_BITS-1:0]         dv_low_ff [QUOT_BITS][3], dv_low_in [QUOT_BITS][3];
   logic [QUOT_BITS-1:0]         dv_q_ff [QUOT_BITS][3], dv_q_in [QUOT_BITS][3];
   logic [DEN_W-1:0]             dv_den_ff [QUOT_BITS], dv_den_in [QUOT_BITS];

   norm_type                     nrm_ff [3], nrm_in [3];
   side_type                     out_ff;

   assign busy   = busy_ff;
   assign accept = start & ~busy_ff;

   assign va[0] = req_vertex_a_x;  assign va[1] = req_vertex_a_y;  assign va[2] = req_vertex_a_z;
   assign vb[0] = req_vertex_b_x;  assign vb[1] = req_vertex_b_y;  assign vb[2] = req_vertex_b_z;
   assign vc[0] = req_vertex_c_x;  assign vc[1] = req_vertex_c_y;  assign vc[2] = req_vertex_c_z;

   // Advance the valid bits one stage per cycle.
   assign vld_in = {vld_ff[NUM_ST-2:0], accept};

   // Edges and box.
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         e1_in[i]  = EW'(vb[i]) - EW'(va[i]);
         e2_in[i]  = EW'(vc[i]) - EW'(vb[i]);
         box_lo[i] = va[i];
         box_hi[i] = va[i];
         if (vb[i] < box_lo[i]) box_lo[i] = vb[i];
         if (vb[i] > box_hi[i]) box_hi[i] = vb[i];
         if (vc[i] < box_lo[i]) box_lo[i] = vc[i];
         if (vc[i] > box_hi[i]) box_hi[i] = vc[i];
      end
   end

   // Six products of edge components.
   always_comb begin
      prod_in[0] = e1_ff[1] * e2_ff[2];
      prod_in[1] = e1_ff[2] * e2_ff[1];
      prod_in[2] = e1_ff[2] * e2_ff[0];
      prod_in[3] = e1_ff[0] * e2_ff[2];
      prod_in[4] = e1_ff[0] * e2_ff[1];
      prod_in[5] = e1_ff[1] * e2_ff[0];
   end

   // Exact cross product.
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         cross_in[i] = XW'(prod_ff[2*i]) - XW'(prod_ff[2*i+1]);
      end
   end

   // Sign and magnitude; all-zero marks a degenerate triangle.
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         neg_c[i]  = cross_ff[i][XW-1];
         mag_in[i] = neg_c[i] ? XW'(-cross_ff[i]) : XW'(cross_ff[i]);
      end
      deg_c = (cross_ff[0] == '0) && (cross_ff[1] == '0) && (cross_ff[2] == '0);
   end

   // Bit length of the largest magnitude.
   always_comb begin
      logic [XW-1:0] or_all;
      or_all = mag_ff[0] | mag_ff[1] | mag_ff[2];
      len_in = '0;
      for (int b = 0; b < XW; b++) begin
         if (or_all[b]) len_in = MLW'(b + 1);
      end
   end

   // Scale by 2^(31 - len): left shifts are exact, right shifts truncate.
   always_comb begin
      logic [SH_W-1:0] shifted;
      for (int i = 0; i < 3; i++) begin
         shifted = {mag2_ff[i], {TARGET_BITS{1'b0}}} >> len_ff;
         m_c[i]  = shifted[TARGET_BITS-1:0];
      end
   end

   // Squares and their sum.
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         sq_in[i] = SQ_W'(side_ff[ST_NORM].m[i]) * SQ_W'(side_ff[ST_NORM].m[i]);
      end
      s_in = RAD_W'(sq_ff[0]) + RAD_W'(sq_ff[1]) + RAD_W'(sq_ff[2]);
   end

   // Square root, one root bit per stage.
   always_comb begin
      logic [RAD_W-1:0]        rad_p;
      logic [ROOT_REM_W-1:0]   rem_p;
      logic [ROOT_W-1:0]       root_p;
      logic [ROOT_REM_W+1:0]   t;
      logic [ROOT_REM_W+1:0]   trial;
      logic                    ge;
      for (int j = 0; j < ROOT_STEPS; j++) begin
         if (j == 0) begin
            rad_p  = s_ff;
            rem_p  = '0;
            root_p = '0;
         end else begin
            rad_p  = rt_rad_ff[j-1];
            rem_p  = rt_rem_ff[j-1];
            root_p = rt_root_ff[j-1];
         end
         t     = {rem_p, rad_p[RAD_W-1 -: 2]};
         trial = (ROOT_REM_W + 2)'({root_p, 2'b01});
         ge    = (t >= trial);
         rt_rem_in[j]  = ge ? ROOT_REM_W'(t - trial) : ROOT_REM_W'(t);
         rt_root_in[j] = {root_p[ROOT_W-2:0], ge};
         rt_rad_in[j]  = rad_p << 2;
      end
   end

   // Divide setup: numerator m * 2^15 + L over 2L rounds half away from zero.
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         num_in[i] = NUM_W'({side_ff[ST_PREP-1].m[i], {QUOT_BITS{1'b0}}})
                   + NUM_W'(rt_root_ff[ROOT_STEPS-1]);
      end
      den_in = {rt_root_ff[ROOT_STEPS-1], 1'b0};
   end

   // Restoring divide, one quotient bit per stage in each of three lanes.
   always_comb begin
      logic [DEN_W-1:0]     rem_p;
      logic [QUOT_BITS-1:0] low_p;
      logic [QUOT_BITS-1:0] q_p;
      logic [DEN_W-1:0]     den_p;
      logic [DEN_W:0]       t;
      logic                 ge;
      for (int j = 0; j < QUOT_BITS; j++) begin
         den_p         = (j == 0) ? den_ff : dv_den_ff[j-1];
         dv_den_in[j]  = den_p;
         for (int i = 0; i < 3; i++) begin
            if (j == 0) begin
               rem_p = DEN_W'(num_ff[i][NUM_W-1:QUOT_BITS]);
               low_p = num_ff[i][QUOT_BITS-1:0];
               q_p   = '0;
            end else begin
               rem_p = dv_rem_ff[j-1][i];
               low_p = dv_low_ff[j-1][i];
               q_p   = dv_q_ff[j-1][i];
            end
            t  = {rem_p, low_p[QUOT_BITS-1]};
            ge = (t >= {1'b0, den_p});
            dv_rem_in[j][i] = ge ? DEN_W'(t - {1'b0, den_p}) : DEN_W'(t);
            dv_low_in[j][i] = low_p << 1;
            dv_q_in[j][i]   = {q_p[QUOT_BITS-2:0], ge};
         end
      end
   end

   // Apply sign; drop the normal of a degenerate triangle.
   always_comb begin
      logic [QUOT_BITS-1:0] q;
      for (int i = 0; i < 3; i++) begin
         q = dv_q_ff[QUOT_BITS-1][i];
         if (side_ff[ST_OUT-1].deg)
            nrm_in[i] = '0;
         else if (side_ff[ST_OUT-1].neg[i])
            nrm_in[i] = -NORM_W'(q);
         else
            nrm_in[i] = NORM_W'(q);
      end
   end

   // Side data: box enters at the edge stage, flags and scaled magnitudes later.
   always_comb begin
      side_in[0] = '0;
      for (int i = 0; i < 3; i++) begin
         side_in[0].lo[i] = box_lo[i];
         side_in[0].hi[i] = box_hi[i];
      end
      for (int k = 1; k < ST_OUT; k++) begin
         side_in[k] = side_ff[k-1];
      end
      side_in[ST_MAG].neg = neg_c;
      side_in[ST_MAG].deg = deg_c;
      for (int i = 0; i < 3; i++) begin
         side_in[ST_NORM].m[i] = m_c[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b1;
         vld_ff  <= '0;
      end else begin
         busy_ff <= 1'b0;
         vld_ff  <= vld_in;
      end
   end

   // Payload registers load every cycle; the valid bits say what counts.
   always_ff @(posedge clock) begin
      for (int k = 0; k < ST_OUT; k++) side_ff[k] <= side_in[k];
      for (int i = 0; i < 3; i++) begin
         e1_ff[i]    <= e1_in[i];
         e2_ff[i]    <= e2_in[i];
         cross_ff[i] <= cross_in[i];
         mag_ff[i]   <= mag_in[i];
         mag2_ff[i]  <= mag_ff[i];
         sq_ff[i]    <= sq_in[i];
         num_ff[i]   <= num_in[i];
         nrm_ff[i]   <= nrm_in[i];
      end
      for (int i = 0; i < 6; i++) prod_ff[i] <= prod_in[i];
      len_ff <= len_in;
      s_ff   <= s_in;
      for (int j = 0; j < ROOT_STEPS; j++) begin
         rt_rad_ff[j]  <= rt_rad_in[j];
         rt_rem_ff[j]  <= rt_rem_in[j];
         rt_root_ff[j] <= rt_root_in[j];
      end
      den_ff <= den_in;
      for (int j = 0; j < QUOT_BITS; j++) begin
         dv_den_ff[j] <= dv_den_in[j];
         for (int i = 0; i < 3; i++) begin
            dv_rem_ff[j][i] <= dv_rem_in[j][i];
            dv_low_ff[j][i] <= dv_low_in[j][i];
            dv_q_ff[j][i]   <= dv_q_in[j][i];
         end
      end
      out_ff <= side_ff[ST_OUT-1];
   end

   assign rsp_valid      = vld_ff[ST_OUT];
   assign rsp_normal_x   = nrm_ff[0];
   assign rsp_normal_y   = nrm_ff[1];
   assign rsp_normal_z   = nrm_ff[2];
   assign rsp_box_low_x  = out_ff.lo[0];
   assign rsp_box_low_y  = out_ff.lo[1];
   assign rsp_box_low_z  = out_ff.lo[2];
   assign rsp_box_high_x = out_ff.hi[0];
   assign rsp_box_high_y = out_ff.hi[1];
   assign rsp_box_high_z = out_ff.hi[2];
   assign rsp_degenerate = out_ff.deg;

   // Every accepted beat comes out as a result once it has passed every stage.
   a_latency : assert property (@(posedge clock) disable iff (reset)
      accept |-> ##NUM_ST rsp_valid)
      else $error("result missing after pipe latency");

   a_deg_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_degenerate |->
         rsp_normal_x == '0 && rsp_normal_y == '0 && rsp_normal_z == '0)
      else $error("degenerate result with nonzero normal");

   a_box_order : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_box_low_x <= rsp_box_high_x && rsp_box_low_y <= rsp_box_high_y
                 && rsp_box_low_z <= rsp_box_high_z)
      else $error("box low above box high");

   a_unit_range : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_degenerate |->
         rsp_normal_x <= NORM_W'(NORM_ONE) && rsp_normal_x >= -NORM_W'(NORM_ONE)
         && rsp_normal_y <= NORM_W'(NORM_ONE) && rsp_normal_y >= -NORM_W'(NORM_ONE)
         && rsp_normal_z <= NORM_W'(NORM_ONE) && rsp_normal_z >= -NORM_W'(NORM_ONE))
      else $error("normal component beyond one");

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 100ps

module tb;
   import tunb_pkg::*;

   localparam int CB          = 24;
   localparam int RAND_BEATS  = 1850;
   localparam int FIXED_BEATS = 17;
   localparam int TOTAL_BEATS = RAND_BEATS + FIXED_BEATS;
   localparam int DRAIN       = 80;
   localparam int CYCLE_CAP   = 400000;

   typedef logic signed [CB-1:0] coord_type;

   typedef struct {
      coord_type v[9];   // ax ay az bx by bz cx cy cz
   } triangle_type;

   typedef struct {
      norm_type  n[3];
      coord_type lo[3];
      coord_type hi[3];
      logic      degen;
   } facet_type;

   logic      clock = 1'b0;
   logic      reset = 1'b1;
   logic      start = 1'b0;
   logic      busy;
   coord_type req_v[9];
   logic      rsp_valid;
   norm_type  rsp_n[3];
   coord_type rsp_lo[3], rsp_hi[3];
   logic      rsp_degenerate;

   triangle_type pending_tris[$];
   facet_type    expected_facets[$];
   int           beats_taken = 0;
   int           cycle_count = 0;
   int           fail_count  = 0;
   string        axis_name [3] = '{"x", "y", "z"};

   always #1 clock = ~clock;

   triangle_unit_normal_and_box #(.COORD_BITS(CB)) dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_vertex_a_x(req_v[0]), .req_vertex_a_y(req_v[1]), .req_vertex_a_z(req_v[2]),
      .req_vertex_b_x(req_v[3]), .req_vertex_b_y(req_v[4]), .req_vertex_b_z(req_v[5]),
      .req_vertex_c_x(req_v[6]), .req_vertex_c_y(req_v[7]), .req_vertex_c_z(req_v[8]),
      .rsp_valid(rsp_valid),
      .rsp_normal_x(rsp_n[0]), .rsp_normal_y(rsp_n[1]), .rsp_normal_z(rsp_n[2]),
      .rsp_box_low_x(rsp_lo[0]), .rsp_box_low_y(rsp_lo[1]), .rsp_box_low_z(rsp_lo[2]),
      .rsp_box_high_x(rsp_hi[0]), .rsp_box_high_y(rsp_hi[1]),
      .rsp_box_high_z(rsp_hi[2]),
      .rsp_degenerate(rsp_degenerate)
   );

   // Integer square root, floor, of a 64-bit radicand.
   function automatic logic [63:0] floor_root(logic [63:0] rad);
      logic [63:0] root, bitv;
      root = '0;
      bitv = 64'h1 << 62;
      while (bitv > rad) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (rad >= root + bitv) begin
            rad  = rad - (root + bitv);
            root = (root >> 1) + bitv;
         end else begin
            root = root >> 1;
         end
         bitv = bitv >> 2;
      end
      return root;
   endfunction

   // Work out the unit normal of (B-A) x (C-B) and the box of the vertices.
   function automatic facet_type facet_of(triangle_type t);
      facet_type f;
      logic signed [127:0] p[9], e1[3], e2[3], cr[3];
      logic [127:0] mg[3], sh;
      logic [63:0] m[3], sum, len, q;
      logic neg[3];
      int maxlen;
      maxlen = 0;
      for (int i = 0; i < 9; i++) p[i] = 128'(t.v[i]);
      for (int i = 0; i < 3; i++) begin
         f.lo[i] = t.v[i];
         f.hi[i] = t.v[i];
         if (t.v[3+i] < f.lo[i]) f.lo[i] = t.v[3+i];
         if (t.v[3+i] > f.hi[i]) f.hi[i] = t.v[3+i];
         if (t.v[6+i] < f.lo[i]) f.lo[i] = t.v[6+i];
         if (t.v[6+i] > f.hi[i]) f.hi[i] = t.v[6+i];
         e1[i] = p[3+i] - p[i];
         e2[i] = p[6+i] - p[3+i];
      end
      cr[0] = e1[1] * e2[2] - e1[2] * e2[1];
      cr[1] = e1[2] * e2[0] - e1[0] * e2[2];
      cr[2] = e1[0] * e2[1] - e1[1] * e2[0];
      for (int i = 0; i < 3; i++) begin
         neg[i] = cr[i] < 0;
         mg[i]  = neg[i] ? -cr[i] : cr[i];
         for (int b = 0; b < 128; b++) begin
            if (mg[i][b] && b + 1 > maxlen) maxlen = b + 1;
         end
      end
      f.degen = (maxlen == 0);
      for (int i = 0; i < 3; i++) f.n[i] = '0;
      if (!f.degen) begin
         // Scale so the largest magnitude sits in [2^30, 2^31).
         for (int i = 0; i < 3; i++) begin
            if (maxlen > TARGET_BITS) sh = mg[i] >> (maxlen - TARGET_BITS);
            else sh = mg[i] << (TARGET_BITS - maxlen);
            m[i] = sh[63:0];
         end
         sum = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
         len = floor_root(sum);
         // Round half away from zero.
         for (int i = 0; i < 3; i++) begin
            q = ((m[i] << 15) + len) / (len << 1);
            if (neg[i]) q = -q;
            f.n[i] = q[15:0];
         end
      end
      return f;
   endfunction

   function automatic triangle_type make_tri(input int ax, ay, az, bx, by, bz, cx, cy, cz);
      triangle_type t;
      t.v[0] = CB'(ax); t.v[1] = CB'(ay); t.v[2] = CB'(az);
      t.v[3] = CB'(bx); t.v[4] = CB'(by); t.v[5] = CB'(bz);
      t.v[6] = CB'(cx); t.v[7] = CB'(cy); t.v[8] = CB'(cz);
      return t;
   endfunction

   // Random triangle: full range, a small one near a random point, or a flat one.
   function automatic triangle_type random_tri();
      triangle_type t;
      int kind, spread;
      kind = $urandom_range(0, 9);
      spread = 1 << $urandom_range(0, 22);
      for (int i = 0; i < 9; i++) t.v[i] = CB'($urandom());
      if (kind >= 3 && kind <= 7) begin
         for (int i = 3; i < 9; i++) begin
            t.v[i] = CB'(t.v[i%3] + $signed($urandom_range(0, 2*spread)) - spread);
         end
      end else if (kind == 8) begin
         // collinear: C = B + (B - A)
         for (int i = 0; i < 3; i++) begin
            t.v[3+i] = CB'(t.v[i] + $signed($urandom_range(0, 2*spread)) - spread);
            t.v[6+i] = t.v[3+i] + (t.v[3+i] - t.v[i]);
         end
      end else if (kind == 9) begin
         // each coordinate of A copied into B or C, picked per axis
         for (int i = 0; i < 3; i++) t.v[3*$urandom_range(1, 2)+i] = t.v[i];
      end
      return t;
   endfunction

   initial begin
      int mx, mn, one;
      mx  = 8388607;
      mn  = -8388608;
      one = 4096;
      // all zero, flat
      pending_tris.push_back(make_tri(0, 0, 0, 0, 0, 0, 0, 0, 0));
      pending_tris.push_back(make_tri(mx, mx, mx, mx, mx, mx, mx, mx, mx));
      pending_tris.push_back(make_tri(mn, mn, mn, mx, mx, mx, mn, mn, mn));
      // unit triangles in each plane; both windings in the xy and yz planes
      pending_tris.push_back(make_tri(0, 0, 0, one, 0, 0, one, one, 0));
      pending_tris.push_back(make_tri(0, 0, 0, 0, one, 0, one, one, 0));
      pending_tris.push_back(make_tri(0, 0, 0, 0, one, 0, 0, one, one));
      pending_tris.push_back(make_tri(0, 0, 0, 0, 0, one, one, 0, one));
      pending_tris.push_back(make_tri(0, 0, 0, 0, 0, one, 0, one, one));
      // largest cross product from opposite extremes
      pending_tris.push_back(make_tri(mn, mn, 0, mx, mn, 0, mx, mx, 0));
      pending_tris.push_back(make_tri(mx, mx, mx, mn, mx, mn, mn, mn, mx));
      pending_tris.push_back(make_tri(mn, mx, mn, mx, mn, mx, mn, mn, mn));
      // small nonzero cross products with axis and diagonal normals, then a mixed one
      pending_tris.push_back(make_tri(0, 0, 0, 1, 0, 0, 1, 1, 0));
      pending_tris.push_back(make_tri(0, 0, 0, 1, 0, 0, 0, 1, 1));
      pending_tris.push_back(make_tri(1, 1, 1, -1, 1, -1, -1, -1, 1));
      pending_tris.push_back(make_tri(-1, -1, -1, mx, 5, -7, 3, mn, 11));
      // collinear at large and small scale
      pending_tris.push_back(make_tri(mn, mn, mn, 0, 0, 0, mx, mx, mx));
      pending_tris.push_back(make_tri(-2, 4, 6, 0, 0, 0, 2, -4, -6));
      for (int k = 0; k < RAND_BEATS; k++) pending_tris.push_back(random_tri());

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // wait until every beat is taken and every result has come back
      while (beats_taken < TOTAL_BEATS || expected_facets.size() != 0) @(posedge clock);
      repeat (DRAIN) @(posedge clock);
      if (fail_count == 0 && expected_facets.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   // Driver: take the beat on the edge, then offer the next one or idle.
   always @(posedge clock) begin
      int idle_pct, phase;
      triangle_type t;
      phase = (beats_taken * 4) / TOTAL_BEATS;
      case (phase)
         1: idle_pct = 57;
         2: idle_pct = 11;
         default: idle_pct = 0;
      endcase
      if (reset) begin
         start <= 1'b0;
         for (int i = 0; i < 9; i++) req_v[i] <= '0;
      end else begin
         if (start && !busy) begin
            for (int i = 0; i < 9; i++) t.v[i] = req_v[i];
            expected_facets.push_back(facet_of(t));
            beats_taken++;
         end
         // hold the current beat until it is taken
         if (!(start && busy)) begin
            if (pending_tris.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
               t = pending_tris.pop_front();
               for (int i = 0; i < 9; i++) req_v[i] <= t.v[i];
               start <= 1'b1;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // Monitor: every strobe must match the oldest expectation.
   always @(posedge clock) begin
      facet_type f;
      cycle_count++;
      if (cycle_count > CYCLE_CAP) begin
         $display("Regression FAIL");
         $finish;
      end
      if (!reset && rsp_valid) begin
         if (expected_facets.size() == 0) begin
            $error("result beat with no triangle outstanding");
            fail_count++;
         end else begin
            f = expected_facets.pop_front();
            for (int i = 0; i < 3; i++) begin
               if (rsp_n[i] !== f.n[i]) begin
                  $error("normal_%s exp %0d got %0d", axis_name[i], f.n[i], rsp_n[i]);
                  fail_count++;
               end
               if (rsp_lo[i] !== f.lo[i]) begin
                  $error("box_low_%s exp %0d got %0d", axis_name[i], f.lo[i], rsp_lo[i]);
                  fail_count++;
               end
               if (rsp_hi[i] !== f.hi[i]) begin
                  $error("box_high_%s exp %0d got %0d", axis_name[i], f.hi[i], rsp_hi[i]);
                  fail_count++;
               end
            end
            if (rsp_degenerate !== f.degen) begin
               $error("degenerate exp %0b got %0b", f.degen, rsp_degenerate);
               fail_count++;
            end
         end
      end
   end

endmodule
